>>> src/cac_pkg.sv
// shared types and constants for the checkerboard alpha compositor
package cac_pkg;

    localparam int LINE_WIDTH_W = 13;
    localparam int GRID_STEP_W  = 8;
    localparam int PIXEL_W      = 32;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd1;
    localparam logic [GRID_STEP_W-1:0]  GRID_STEP_RESET  = 8'd10;
    localparam logic [PIXEL_W-1:0]      GRID_COLOR_RESET = 32'h0040_4040;

    // even cells are darker than the grid colour by this amount
    localparam logic [PIXEL_W-1:0]      EVEN_CELL_DELTA  = 32'h0010_1010;

    localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_LINE_WIDTH = 2'd0,
        REG_GRID_STEP  = 2'd1,
        REG_GRID_COLOR = 2'd2
    } cac_reg_t;

    typedef struct packed {
        logic [LINE_WIDTH_W-1:0] line_width;
        logic [GRID_STEP_W-1:0]  grid_step;
        logic [PIXEL_W-1:0]      grid_color;
    } cac_cfg_t;

endpackage

>>> src/checkerboard_alpha_composite.sv
// top level: checkerboard alpha compositor for an argb pixel stream
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------
//  s_axis   | in        | s_tvalid/s_tready | s_tdata pixel_in, s_tuser frame_start
//  m_axis   | out       | m_tvalid/m_tready | m_tdata pixel_out
//  cfg      | in        | cfg_valid/ready   | cfg_index register, cfg_data value
//
// one word per cycle sustained while m_tready stays high; a word passes the input
// register, then blend logic into the output register, and m_tvalid rises once
// the word is in the output register
// counters advance at input accept, frame_start clears them for that word
// a stalled output holds; s_tready drops only when both stages are full
// reset gives line_width 1, grid_step 10, grid_color 0x00404040, counters at zero
module checkerboard_alpha_composite #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pixel_in
    input  logic        s_tuser,   // [0] frame_start
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] pixel_out
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cac_pkg::cac_cfg_t cfg_reg, cfg_next;

    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_pixel_reg;
    logic        s1_diff_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_pixel_reg;

    logic        in_accept, out_load, parity_diff;
    logic [31:0] blend_result;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cac_pkg::REG_LINE_WIDTH: cfg_next.line_width = cfg_data[12:0];
                cac_pkg::REG_GRID_STEP:  cfg_next.grid_step  = cfg_data[7:0];
                cac_pkg::REG_GRID_COLOR: cfg_next.grid_color = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // two stage pipe: input register, then output register
    assign out_load  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // checker position of the word being accepted
    cac_raster #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_raster (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (in_accept),
        .frame_start(s_tuser),
        .cfg        (cfg_reg),
        .parity_diff(parity_diff)
    );

    cac_blend u_blend (
        .pixel      (s1_pixel_reg),
        .parity_diff(s1_diff_reg),
        .cfg        (cfg_reg),
        .result     (blend_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width <= cac_pkg::LINE_WIDTH_RESET;
            cfg_reg.grid_step  <= cac_pkg::GRID_STEP_RESET;
            cfg_reg.grid_color <= cac_pkg::GRID_COLOR_RESET;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= s_tdata;
            s1_diff_reg  <= parity_diff;
        end
        if (out_load)
            out_pixel_reg <= blend_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;

endmodule

>>> src/cac_raster.sv
// raster column and checker cell counters
module cac_raster #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              frame_start,
    input  cac_pkg::cac_cfg_t cfg,
    output logic              parity_diff
);

    localparam int CW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int LW = (CW + 1 > cac_pkg::LINE_WIDTH_W) ? CW + 1 : cac_pkg::LINE_WIDTH_W;
    localparam logic [LW-1:0] MAX_WIDTH = LW'(MAX_LINE_WIDTH);

    logic [CW-1:0] column_reg, column_next;
    logic [7:0]    col_cell_reg, col_cell_next;
    logic          col_par_reg, col_par_next;
    logic [7:0]    row_cell_reg, row_cell_next;
    logic          row_par_reg, row_par_next;

    logic [CW-1:0] col_cur;
    logic [7:0]    col_cell_cur, row_cell_cur;
    logic          col_par_cur, row_par_cur;
    logic [LW-1:0] width, width_raw, col_plus;
    logic [7:0]    step;
    logic [8:0]    col_cell_inc, row_cell_inc;
    logic          row_end, col_wrap, row_wrap;

    // frame start clears the counters before this pixel is used
    always_comb
    begin
        col_cur      = frame_start ? '0 : column_reg;
        col_cell_cur = frame_start ? '0 : col_cell_reg;
        col_par_cur  = frame_start ? 1'b0 : col_par_reg;
        row_cell_cur = frame_start ? '0 : row_cell_reg;
        row_par_cur  = frame_start ? 1'b0 : row_par_reg;
    end

    assign parity_diff = col_par_cur ^ row_par_cur;

    always_comb
    begin
        width_raw = LW'(cfg.line_width);
        if (width_raw == '0)
            width = LW'(1);
        else if (width_raw > MAX_WIDTH)
            width = MAX_WIDTH;
        else
            width = width_raw;
        step = (cfg.grid_step == '0) ? 8'd1 : cfg.grid_step;
    end

    assign col_plus     = LW'(col_cur) + LW'(1);
    assign row_end      = col_plus >= width;
    assign col_cell_inc = {1'b0, col_cell_cur} + 9'd1;
    assign row_cell_inc = {1'b0, row_cell_cur} + 9'd1;
    // reached or passed, so a lowered step ends the cell at once
    assign col_wrap     = col_cell_inc >= {1'b0, step};
    assign row_wrap     = row_cell_inc >= {1'b0, step};

    always_comb
    begin
        column_next   = column_reg;
        col_cell_next = col_cell_reg;
        col_par_next  = col_par_reg;
        row_cell_next = row_cell_reg;
        row_par_next  = row_par_reg;
        if (advance)
        begin
            row_cell_next = row_cell_cur;
            row_par_next  = row_par_cur;
            if (row_end)
            begin
                column_next   = '0;
                col_cell_next = '0;
                col_par_next  = 1'b0;
                row_cell_next = row_wrap ? 8'd0 : row_cell_inc[7:0];
                row_par_next  = row_par_cur ^ row_wrap;
            end
            else
            begin
                column_next   = col_plus[CW-1:0];
                col_cell_next = col_wrap ? 8'd0 : col_cell_inc[7:0];
                col_par_next  = col_par_cur ^ col_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            col_cell_reg <= '0;
            col_par_reg  <= 1'b0;
            row_cell_reg <= '0;
            row_par_reg  <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            col_cell_reg <= col_cell_next;
            col_par_reg  <= col_par_next;
            row_cell_reg <= row_cell_next;
            row_par_reg  <= row_par_next;
        end
    end

endmodule

>>> src/cac_blend.sv
// per-byte alpha blend of a pixel over the checker background
module cac_blend (
    input  logic [31:0]       pixel,
    input  logic              parity_diff,
    input  cac_pkg::cac_cfg_t cfg,
    output logic [31:0]       result
);

    logic [31:0] bkg;
    logic [7:0]  alpha, inv_alpha;
    logic [15:0] sum [4];
    logic [31:0] blended;

    assign bkg       = parity_diff ? cfg.grid_color
                                   : cfg.grid_color - cac_pkg::EVEN_CELL_DELTA;
    assign alpha     = pixel[31:24];
    assign inv_alpha = 8'd255 - alpha;

    // four independent byte lanes, alpha byte included
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum[i] = 16'(bkg[8*i +: 8] * inv_alpha) + 16'(pixel[8*i +: 8] * alpha);
            blended[8*i +: 8] = sum[i][15:8];
        end
    end

    assign result = (alpha == cac_pkg::OPAQUE_ALPHA) ? pixel : blended;

endmodule

>>> src/cac_checker.sv
// port level checks for the checkerboard alpha compositor, with bind
module cac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // a free output side never blocks the input side
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // opaque pixel comes out unchanged through both registers when not stalled
    a_opaque_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[31:24] == cac_pkg::OPAQUE_ALPHA) ##1 m_tready
        |=> m_tvalid && m_tdata == $past(s_tdata, 2))
        else $error("opaque pixel not passed through");

endmodule

bind checkerboard_alpha_composite cac_checker u_cac_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> tb/sv/composite_check_pkg.sv
`timescale 1ns / 1ps
// pixel predictor and result scoreboard for the checkerboard compositor bench
package composite_check_pkg;
    import cac_pkg::*;

    localparam int LINE_LIMIT = 4096;
    // index with no register behind it, writes there change nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;

    class blend_scoreboard;
        logic [LINE_WIDTH_W-1:0] line_width;
        logic [GRID_STEP_W-1:0]  grid_step;
        logic [PIXEL_W-1:0]      grid_color;

        logic [11:0] column;
        logic [7:0]  column_in_cell;
        logic        column_parity;
        logic [7:0]  row_in_cell;
        logic        row_parity;

        logic [PIXEL_W-1:0] expected_pixels[$];
        int unsigned errors;
        int unsigned pixels;
        int unsigned opaque;
        int unsigned starts;

        function new();
            line_width     = LINE_WIDTH_RESET;
            grid_step      = GRID_STEP_RESET;
            grid_color     = GRID_COLOR_RESET;
            column         = '0;
            column_in_cell = '0;
            column_parity  = 1'b0;
            row_in_cell    = '0;
            row_parity     = 1'b0;
            errors         = 0;
            pixels         = 0;
            opaque         = 0;
            starts         = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_LINE_WIDTH: line_width = data[LINE_WIDTH_W-1:0];
                REG_GRID_STEP:  grid_step  = data[GRID_STEP_W-1:0];
                REG_GRID_COLOR: grid_color = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] blend_byte(logic [7:0] bkg, logic [7:0] pix, logic [7:0] alpha);
            logic [15:0] sum;
            sum = bkg * (8'd255 - alpha) + pix * alpha;
            return sum[15:8];
        endfunction

        // cell counter advance, "reached or passed" ends the cell
        function void step_cell(inout logic [7:0] cnt, inout logic par);
            int eff_step;
            eff_step = (grid_step == 0) ? 1 : int'(grid_step);
            if (int'(cnt) + 1 >= eff_step)
            begin
                cnt = '0;
                par = ~par;
            end
            else
                cnt = cnt + 8'd1;
        endfunction

        // predict the composited pixel for an accepted word, then advance the raster
        function void note_pixel(logic [PIXEL_W-1:0] pix, logic frame_start);
            logic [7:0]         alpha;
            logic [PIXEL_W-1:0] bkg;
            logic [PIXEL_W-1:0] want;
            int                 eff_width;
            alpha = pix[31:24];
            pixels++;
            if (frame_start)
            begin
                starts++;
                column         = '0;
                column_in_cell = '0;
                column_parity  = 1'b0;
                row_in_cell    = '0;
                row_parity     = 1'b0;
            end
            if (alpha == OPAQUE_ALPHA)
            begin
                opaque++;
                want = pix;
            end
            else
            begin
                bkg = (column_parity != row_parity) ? grid_color : grid_color - EVEN_CELL_DELTA;
                for (int i = 0; i < 4; i++)
                    want[8*i +: 8] = blend_byte(bkg[8*i +: 8], pix[8*i +: 8], alpha);
            end
            expected_pixels.push_back(want);

            eff_width = (line_width == 0) ? 1 : int'(line_width);
            if (eff_width > LINE_LIMIT)
                eff_width = LINE_LIMIT;
            if (int'(column) + 1 >= eff_width)
            begin
                column         = '0;
                column_in_cell = '0;
                column_parity  = 1'b0;
                step_cell(row_in_cell, row_parity);
            end
            else
            begin
                column = column + 12'd1;
                step_cell(column_in_cell, column_parity);
            end
        endfunction

        task report(string what);
            // quiet after the first fifty, the count still runs
            if (errors < 50)
                $display("mismatch: %s", what);
            errors++;
        endtask

        task check_pixel(logic [PIXEL_W-1:0] got);
            logic [PIXEL_W-1:0] want;
            if (expected_pixels.size() == 0)
                report($sformatf("pixel_out %h with no word pending", got));
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                    report($sformatf("pixel_out %h, predicted %h", got, want));
            end
        endtask
    endclass

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// top-level bench: drives pixels and register writes, checks every composited word
module tb;
    import cac_pkg::*;
    import composite_check_pkg::*;

    localparam int STALL_LIMIT   = 4000;  // cycles with no word moving anywhere
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_WORDS   = 50;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [31:0] pixel_in
    logic        s_tuser   = 1'b0;  // [0] frame_start
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // [31:0] pixel_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_LINE_WIDTH;
    logic [31:0] cfg_data  = '0;

    // idle rates in percent of cycles, changed per phase
    int send_idle_pct = 16;
    int recv_idle_pct = 69;
    int quiet_cycles  = 0;
    int settings      = 0;

    blend_scoreboard sb;

    checkerboard_alpha_composite #(
        .MAX_LINE_WIDTH(LINE_LIMIT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // receiver stalls at random, one decision per cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // observe handshakes at the edge: register writes and input words feed the
    // predictor, output words are checked against the oldest prediction
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (s_tvalid && s_tready)
            sb.note_pixel(s_tdata, s_tuser);
        if (m_tvalid && m_tready)
            sb.check_pixel(m_tdata);
    end

    // watchdog: the run is hung if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: nothing moved for %0d cycles, %0d words pending",
                     STALL_LIMIT, sb.pending());
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one pixel word, with random idle cycles ahead of it
    task automatic send_pixel(input logic [31:0] pix, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // one register write, valid stays up for the caller to lower
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // full register set, only called with the pipeline empty
    task automatic load_settings(input logic [12:0] lw, input logic [7:0] step,
                                 input logic [31:0] color, input bit poke_unused);
        cfg_write(REG_LINE_WIDTH, {19'd0, lw});
        cfg_write(REG_GRID_STEP, {24'd0, step});
        cfg_write(REG_GRID_COLOR, color);
        if (poke_unused)
            cfg_write(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // alpha skewed toward the opaque pass-through and the blend extremes
    function automatic logic [31:0] random_pixel();
        logic [7:0] alpha;
        case ($urandom_range(9))
            0, 1:    alpha = OPAQUE_ALPHA;
            2:       alpha = 8'h00;
            3:       alpha = 8'hfe;
            default: alpha = 8'($urandom_range(255));
        endcase
        return {alpha, 24'($urandom)};
    endfunction

    // mostly short rows so row parity moves, sometimes the edges of the range
    function automatic logic [12:0] random_width();
        case ($urandom_range(9))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'd4097;
            4:       return 13'h1fff;
            default: return 13'($urandom_range(24, 2));
        endcase
    endfunction

    function automatic logic [7:0] random_step();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(6, 2));
        endcase
    endfunction

    function automatic logic [31:0] random_color();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return EVEN_CELL_DELTA;
            3:       return 32'h000f_0f0f;  // even cells wrap below zero
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic start;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, no frame start: counters run on from reset,
        // a one-pixel row so every word ends a row
        send_pixel(32'hff12_3456, 1'b0);
        send_pixel(32'hff00_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h00ff_ffff, 1'b0);
        send_pixel(32'h80a5_a5a5, 1'b0);
        send_pixel(32'hfeff_ffff, 1'b0);
        send_pixel(32'h0100_0000, 1'b0);
        drain();

        // zero width and zero step act as one, black grid wraps the even cells
        load_settings(13'd0, 8'd0, 32'h0000_0000, 1'b1);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h40ff_ffff, 1'b0);
        send_pixel(32'h40ff_ffff, 1'b0);
        send_pixel(32'hc012_3456, 1'b0);
        drain();

        // width beyond the maximum saturates; run three pixels into a cell of five
        load_settings(13'h1fff, 8'd5, 32'hffff_ffff, 1'b0);
        send_pixel(32'h20ff_ffff, 1'b1);
        send_pixel(32'h2000_0000, 1'b0);
        send_pixel(32'h7f80_8080, 1'b0);
        drain();

        // step lowered under the cell counter: the cell ends at the next pixel
        load_settings(13'h1fff, 8'd2, 32'hffff_ffff, 1'b0);
        send_pixel(32'h1011_2233, 1'b0);
        send_pixel(32'h1011_2233, 1'b0);
        send_pixel(32'h1011_2233, 1'b0);
        send_pixel(32'h1011_2233, 1'b0);
        drain();

        // grid colour equal to the even-cell offset, widest step, restart mid-row
        load_settings(13'd3, 8'd255, EVEN_CELL_DELTA, 1'b0);
        send_pixel(32'h9955_aa55, 1'b1);
        send_pixel(32'h9955_aa55, 1'b0);
        send_pixel(32'h9955_aa55, 1'b1);
        send_pixel(32'h00ff_00ff, 1'b0);
        send_pixel(32'hffff_ffff, 1'b0);
        drain();

        // random frames: sender-light then receiver-light idling, then none
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            load_settings(random_width(), random_step(), random_color(), phase == 5);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // most phases open with a frame start, odd restarts inside
                start = (n == 0) ? ($urandom_range(4) != 0) : ($urandom_range(39) == 0);
                // hold the stream mid-frame until the pipeline runs dry
                if (phase == 4 && n == PHASE_WORDS / 2)
                    drain();
                send_pixel(random_pixel(), start);
            end
            drain();
        end

        // pipeline is two deep, give a few more cycles for stray words
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d predicted words never came out", sb.pending()));

        $display("covered %0d pixels (%0d opaque, %0d frame starts) over %0d register settings",
                 sb.pixels, sb.opaque, sb.starts, settings);
        $display("incl. zero and saturated widths, zero and lowered steps, wrapping grid colours");
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> checkerboard_alpha_composite.f
src/cac_pkg.sv
src/cac_raster.sv
src/cac_blend.sv
src/checkerboard_alpha_composite.sv
src/cac_checker.sv
tb/sv/composite_check_pkg.sv
tb/sv/tb.sv
